>>> hdl/pulse_tachometer_overspeed_defines.svh
// Assertion macros shared by the tachometer checker.
`ifndef PULSE_TACHOMETER_OVERSPEED_DEFINES_SVH
`define PULSE_TACHOMETER_OVERSPEED_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define PTO_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define PTO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/pto_pkg.sv
// Shared constants, register codes and types of the pulse tachometer.
package pto_pkg;

	// Pulse handling.
	localparam int SYNC_PULSES = 3;
	localparam int SYNC_W = 2;
	localparam int TIME_WIDTH = 32;

	// Register and field widths.
	localparam int SCALE_W = 33;
	localparam int SPEED_W = 29;
	localparam int PPM_W = 7;

	localparam logic [SYNC_W-1:0] SYNC_CNT = SYNC_W'(SYNC_PULSES);
	localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

	// Register reset values.
	localparam logic [SCALE_W-1:0] SCALE_RST = 33'd5400000000;
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 29'd67500;
	localparam logic [PPM_W-1:0] PPM_RST = 7'd11;

	// Configuration port.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_SCALE = 2'd0;
	localparam logic [IDX_W-1:0] REG_MAX_SPEED = 2'd1;
	localparam logic [IDX_W-1:0] REG_PPM = 2'd2;

	// Divider: one quotient bit per cycle.
	localparam int DIV_STEPS = SCALE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	// Queue between the pulse timer and the divider.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam logic [QCNT_W-1:0] QFULL_CNT = QCNT_W'(QDEPTH);

	// Configuration registers as seen by the front and back parts.
	typedef struct packed {
		logic [SCALE_W-1:0] speed_scale;
		logic [SPEED_W-1:0] max_speed;
		logic [PPM_W-1:0] pulses_per_measure;
	} cfg_t;

	// Status of the queue as seen by its reader and writer.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

>>> hdl/pto_front.sv
// Pulse timer: syncs to the sensor, times low phases and sums them.
module pto_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pto_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              pin_level,
	input  pto_pkg::qstat_t                   qstat,
	output logic                              push,
	output logic [pto_pkg::TIME_WIDTH-1:0]    push_accum
);

	typedef enum logic [2:0] {
		PH_SYNC = 3'b001,
		PH_WAIT = 3'b010,
		PH_LOW  = 3'b100
	} phase_t;

	phase_t                            phase_q, phase_d;
	logic [pto_pkg::SYNC_W-1:0]        sync_q, sync_d, sync_inc;
	logic                              prev_q;
	logic [pto_pkg::TIME_WIDTH-1:0]    timer_q, timer_d;
	logic [pto_pkg::TIME_WIDTH-1:0]    accum_q, accum_d, accum_sat;
	logic [pto_pkg::TIME_WIDTH:0]      accum_sum;
	logic [pto_pkg::PPM_W-1:0]         pc_q, pc_d, pc_inc;
	logic                              accept, falling, rising, done;

	// Stall whenever the queue cannot take another result.
	assign in_stall = qstat.full;
	assign accept = in_valid && !qstat.full;
	assign falling = prev_q && !pin_level;
	assign rising = !prev_q && pin_level;

	// Saturating sum of the accumulator and the finished low time.
	assign accum_sum = {1'b0, accum_q} + {1'b0, timer_q};
	assign accum_sat = accum_sum[pto_pkg::TIME_WIDTH] ? pto_pkg::TIME_MAX :
		accum_sum[pto_pkg::TIME_WIDTH-1:0];
	assign pc_inc = pc_q + 1'b1;
	assign sync_inc = rising ? sync_q + 1'b1 : sync_q;

	// Next-state logic for one pin sample.
	always_comb begin
		phase_d = phase_q;
		sync_d = sync_q;
		timer_d = timer_q;
		accum_d = accum_q;
		pc_d = pc_q;
		done = 1'b0;
		unique case (phase_q)
			PH_SYNC: begin
				if (sync_q >= pto_pkg::SYNC_CNT) begin
					// Already synced: this sample is handled as a wait sample.
					phase_d = PH_WAIT;
					if (falling) begin
						timer_d = pto_pkg::TIME_WIDTH'(1);
						phase_d = PH_LOW;
					end
				end else begin
					sync_d = sync_inc;
					if (sync_inc >= pto_pkg::SYNC_CNT) begin
						phase_d = PH_WAIT;
					end
				end
			end
			PH_WAIT: begin
				if (falling) begin
					timer_d = pto_pkg::TIME_WIDTH'(1);
					phase_d = PH_LOW;
				end
			end
			PH_LOW: begin
				if (!pin_level) begin
					if (timer_q != pto_pkg::TIME_MAX) begin
						timer_d = timer_q + 1'b1;
					end
				end else begin
					timer_d = '0;
					phase_d = PH_WAIT;
					if (pc_inc >= cfg.pulses_per_measure) begin
						done = 1'b1;
						accum_d = '0;
						pc_d = '0;
					end else begin
						accum_d = accum_sat;
						pc_d = pc_inc;
					end
				end
			end
			default: begin
				phase_d = PH_SYNC;
			end
		endcase
	end

	// A finished measurement goes to the queue with its summed time.
	assign push = accept && done;
	assign push_accum = accum_sat;

	// State registers advance on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			sync_q <= '0;
			prev_q <= 1'b1;
			timer_q <= '0;
			accum_q <= '0;
			pc_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			sync_q <= sync_d;
			prev_q <= pin_level;
			timer_q <= timer_d;
			accum_q <= accum_d;
			pc_q <= pc_d;
		end
	end

endmodule

>>> hdl/pto_fifo.sv
// Two-entry queue of summed low times between the timer and the divider.
module pto_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [pto_pkg::TIME_WIDTH-1:0]    wr_data,
	input  logic                              rd_en,
	output logic [pto_pkg::TIME_WIDTH-1:0]    rd_data,
	output pto_pkg::qstat_t                   qstat
);

	logic [pto_pkg::TIME_WIDTH-1:0] mem_q [pto_pkg::QDEPTH];
	logic [pto_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
	logic [pto_pkg::QCNT_W-1:0]     cnt_q;
	logic                           do_wr, do_rd;

	assign qstat.full = (cnt_q == pto_pkg::QFULL_CNT);
	assign qstat.empty = (cnt_q == '0);
	assign do_wr = wr_en && !qstat.full;
	assign do_rd = rd_en && !qstat.empty;
	assign rd_data = mem_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/pto_back.sv
// Speed unit: divides the scale by the summed time and drives the result beat.
module pto_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pto_pkg::cfg_t                     cfg,
	input  pto_pkg::qstat_t                   qstat,
	input  logic [pto_pkg::TIME_WIDTH-1:0]    q_data,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pto_pkg::SPEED_W-1:0]       speed_rpm,
	output logic                              over_speed
);

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_DIV  = 3'b010,
		BK_DONE = 3'b100
	} bk_state_t;

	bk_state_t                         state_q;
	logic [pto_pkg::TIME_WIDTH-1:0]    div_q, rem_q, rem_next;
	logic [pto_pkg::SCALE_W-1:0]       quo_q;
	logic [pto_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [pto_pkg::TIME_WIDTH:0]      trial, trial_diff;
	logic                              q_bit, load_out;
	logic [pto_pkg::SPEED_W-1:0]       speed_sat;
	logic                              out_valid_q;
	logic [pto_pkg::SPEED_W-1:0]       speed_q;
	logic                              over_q;

	assign q_pop = (state_q == BK_IDLE) && !qstat.empty;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign trial = {rem_q, quo_q[pto_pkg::SCALE_W-1]};
	assign trial_diff = trial - {1'b0, div_q};
	assign q_bit = (trial >= {1'b0, div_q});
	assign rem_next = q_bit ? trial_diff[pto_pkg::TIME_WIDTH-1:0] :
		trial[pto_pkg::TIME_WIDTH-1:0];

	// Zero time gives zero speed; large quotients clamp to the field maximum.
	always_comb begin
		if (div_q == '0) begin
			speed_sat = '0;
		end else if (quo_q[pto_pkg::SCALE_W-1:pto_pkg::SPEED_W] != '0) begin
			speed_sat = pto_pkg::SPEED_MAX;
		end else begin
			speed_sat = quo_q[pto_pkg::SPEED_W-1:0];
		end
	end

	assign load_out = (state_q == BK_DONE) && (!out_valid_q || !out_stall);

	// Divider sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (!qstat.empty) begin
						cnt_q <= '0;
						state_q <= BK_DIV;
					end
				end
				BK_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == pto_pkg::DIV_LAST) begin
						state_q <= BK_DONE;
					end
				end
				BK_DONE: begin
					if (load_out) begin
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	// Divider datapath.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			div_q <= q_data;
			quo_q <= cfg.speed_scale;
			rem_q <= '0;
		end else if (state_q == BK_DIV) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[pto_pkg::SCALE_W-2:0], q_bit};
		end
	end

	// Output register holds the result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			speed_q <= speed_sat;
			over_q <= (speed_sat >= cfg.max_speed);
		end
	end

	assign out_valid = out_valid_q;
	assign speed_rpm = speed_q;
	assign over_speed = over_q;

endmodule

>>> hdl/pulse_tachometer_overspeed.sv
// Top level of the pulse-width tachometer with overspeed flag.
//
// The input channel carries one beat per timebase tick: pin_level, the
// sampled sensor pin. The block skips three low pulses to synchronize, then
// times each low phase and sums the times over pulses_per_measure pulses.
// On the rising edge that closes the last pulse it emits one result beat
// with speed_rpm = speed_scale / summed time and the over_speed flag.
// Input beats are taken one per cycle while in_stall is low. The pulse
// timer hands each finished sum to a two-entry queue; a bit-serial divider
// takes one quotient bit per cycle and takes the next sum from the queue
// only once its last result has gone to the output register.
// in_stall rises only while the queue holds two sums, which takes results
// closer together than the divider time. A stalled result beat holds in the
// output register, and the divider then waits with the next result.
// Reset puts the block back into synchronization, clears all sums and sets
// the registers to their reset values. The APB port writes at byte address
// 8 * index; pready is always high.
module pulse_tachometer_overspeed (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              pin_level,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pto_pkg::SPEED_W-1:0]       speed_rpm,
	output logic                              over_speed,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pto_pkg::ADDR_W-1:0]        paddr,
	input  logic [pto_pkg::DATA_W-1:0]        pwdata,
	output logic [pto_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	pto_pkg::cfg_t                     cfg_q;
	pto_pkg::qstat_t                   qstat;
	logic [pto_pkg::IDX_W-1:0]         reg_idx;
	logic                              push, pop;
	logic [pto_pkg::TIME_WIDTH-1:0]    push_accum, q_data;

	assign pready = 1'b1;
	assign reg_idx = paddr[pto_pkg::ADDR_W-1:3];

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_scale <= pto_pkg::SCALE_RST;
			cfg_q.max_speed <= pto_pkg::MAX_SPEED_RST;
			cfg_q.pulses_per_measure <= pto_pkg::PPM_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				pto_pkg::REG_SCALE: cfg_q.speed_scale <= pwdata[pto_pkg::SCALE_W-1:0];
				pto_pkg::REG_MAX_SPEED: cfg_q.max_speed <= pwdata[pto_pkg::SPEED_W-1:0];
				pto_pkg::REG_PPM: cfg_q.pulses_per_measure <= pwdata[pto_pkg::PPM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (reg_idx)
			pto_pkg::REG_SCALE: prdata = pto_pkg::DATA_W'(cfg_q.speed_scale);
			pto_pkg::REG_MAX_SPEED: prdata = pto_pkg::DATA_W'(cfg_q.max_speed);
			pto_pkg::REG_PPM: prdata = pto_pkg::DATA_W'(cfg_q.pulses_per_measure);
			default: prdata = '0;
		endcase
	end

	pto_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pin_level  (pin_level),
		.qstat      (qstat),
		.push       (push),
		.push_accum (push_accum)
	);

	pto_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_accum),
		.rd_en   (pop),
		.rd_data (q_data),
		.qstat   (qstat)
	);

	pto_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.qstat      (qstat),
		.q_data     (q_data),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.speed_rpm  (speed_rpm),
		.over_speed (over_speed)
	);

endmodule

>>> hdl/pto_checker.sv
// Port-level checker of the tachometer and its bind to the top level.
`include "pulse_tachometer_overspeed_defines.svh"

module pto_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [pto_pkg::SPEED_W-1:0]       speed_rpm,
	input logic                              over_speed,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic                              pready,
	input logic [pto_pkg::ADDR_W-1:0]        paddr,
	input logic [pto_pkg::DATA_W-1:0]        pwdata,
	input logic [pto_pkg::DATA_W-1:0]        prdata
);

	// A stalled result beat stays offered.
	`PTO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")

	// A stalled result beat keeps its payload.
	`PTO_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(speed_rpm) && $stable(over_speed), "result payload changed while stalled")

	// No result beat is offered right after reset.
	`PTO_ASSERT_SAME(a_out_reset, $past(!arst_n), !out_valid, "result beat offered after reset")

	// A write to the pulse count register reads back on the next cycle.
	`PTO_ASSERT_SAME(a_ppm_readback, $past(arst_n && psel && penable && pwrite && pready && (paddr[pto_pkg::ADDR_W-1:3] == pto_pkg::REG_PPM)) && (paddr[pto_pkg::ADDR_W-1:3] == pto_pkg::REG_PPM), (prdata[pto_pkg::DATA_W-1:pto_pkg::PPM_W] == '0) && (prdata[pto_pkg::PPM_W-1:0] == $past(pwdata[pto_pkg::PPM_W-1:0])), "pulse count register readback mismatch")

endmodule

bind pulse_tachometer_overspeed pto_checker u_pto_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.speed_rpm  (speed_rpm),
	.over_speed (over_speed),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.pready     (pready),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata)
);

>>> tb/pulse_tachometer_overspeed_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the pulse tachometer: pin beats in, speed beats checked in order.
module pulse_tachometer_overspeed_tb;

	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_HOLD = 40;

	typedef enum logic [2:0] {
		TACH_SYNC = 3'b001,
		TACH_WAIT = 3'b010,
		TACH_LOW  = 3'b100
	} tach_phase_t;

	typedef struct {
		bit [pto_pkg::SPEED_W-1:0] speed;
		bit                        over;
	} speed_beat_t;

	// Predicts speed beats from accepted pin beats and checks what the block sends.
	class tach_scoreboard;
		bit [pto_pkg::SCALE_W-1:0]    speed_scale;
		bit [pto_pkg::SPEED_W-1:0]    max_speed;
		bit [pto_pkg::PPM_W-1:0]      pulses_per_measure;
		tach_phase_t                  phase;
		bit [pto_pkg::SYNC_W-1:0]     sync_count;
		bit                           prev_level;
		bit [pto_pkg::TIME_WIDTH-1:0] low_timer;
		bit [pto_pkg::TIME_WIDTH-1:0] time_accum;
		bit [pto_pkg::PPM_W-1:0]      pulse_count;
		speed_beat_t                  expected_q[$];
		int                           errors;

		function new();
			speed_scale = pto_pkg::SCALE_RST;
			max_speed = pto_pkg::MAX_SPEED_RST;
			pulses_per_measure = pto_pkg::PPM_RST;
			phase = TACH_SYNC;
			sync_count = '0;
			prev_level = 1'b1;
			low_timer = '0;
			time_accum = '0;
			pulse_count = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [pto_pkg::IDX_W-1:0] idx,
				bit [pto_pkg::DATA_W-1:0] value);
			unique case (idx)
				pto_pkg::REG_SCALE: speed_scale = value[pto_pkg::SCALE_W-1:0];
				pto_pkg::REG_MAX_SPEED: max_speed = value[pto_pkg::SPEED_W-1:0];
				pto_pkg::REG_PPM: pulses_per_measure = value[pto_pkg::PPM_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_pin(bit pin);
			bit                         falling;
			bit                         rising;
			bit [pto_pkg::TIME_WIDTH:0] sum;
			bit [63:0]                  quotient;
			speed_beat_t                beat;
			falling = prev_level && !pin;
			rising = !prev_level && pin;
			prev_level = pin;

			// Skip the first low pulses; the tick that completes the count ends there, a tick already synced falls through.
			if (phase != TACH_WAIT && phase != TACH_LOW) begin
				if (sync_count >= pto_pkg::SYNC_CNT) begin
					phase = TACH_WAIT;
				end else begin
					if (rising)
						sync_count = sync_count + 1'b1;
					if (sync_count >= pto_pkg::SYNC_CNT)
						phase = TACH_WAIT;
					return;
				end
			end

			if (phase == TACH_WAIT) begin
				if (falling) begin
					low_timer = 1;
					phase = TACH_LOW;
				end
				return;
			end

			// Timing a low phase, saturating.
			if (!pin) begin
				if (low_timer != pto_pkg::TIME_MAX)
					low_timer = low_timer + 1'b1;
				return;
			end

			// Rising edge closes the pulse.
			sum = {1'b0, time_accum} + {1'b0, low_timer};
			time_accum = sum[pto_pkg::TIME_WIDTH] ? pto_pkg::TIME_MAX :
				sum[pto_pkg::TIME_WIDTH-1:0];
			low_timer = '0;
			pulse_count = pulse_count + 1'b1;
			phase = TACH_WAIT;

			if (pulse_count >= pulses_per_measure) begin
				quotient = '0;
				if (time_accum != 0)
					quotient = 64'(speed_scale) / 64'(time_accum);
				if (quotient > 64'(pto_pkg::SPEED_MAX))
					quotient = 64'(pto_pkg::SPEED_MAX);
				beat.speed = quotient[pto_pkg::SPEED_W-1:0];
				beat.over = (quotient[pto_pkg::SPEED_W-1:0] >= max_speed);
				expected_q.push_back(beat);
				time_accum = '0;
				pulse_count = '0;
			end
		endfunction

		function void check_speed(logic [pto_pkg::SPEED_W-1:0] spd, logic ovr);
			speed_beat_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: speed beat with none expected, speed_rpm %0d over_speed %0b",
					$time, spd, ovr);
				return;
			end
			want = expected_q.pop_front();
			if (spd !== want.speed) begin
				errors++;
				$display("%0t: speed_rpm expected %0d actual %0d", $time, want.speed, spd);
			end
			if (ovr !== want.over) begin
				errors++;
				$display("%0t: over_speed expected %0b actual %0b", $time, want.over, ovr);
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic                         pin_level;
	logic                         out_valid;
	logic                         out_stall;
	logic [pto_pkg::SPEED_W-1:0]  speed_rpm;
	logic                         over_speed;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [pto_pkg::ADDR_W-1:0]   paddr;
	logic [pto_pkg::DATA_W-1:0]   pwdata;
	logic [pto_pkg::DATA_W-1:0]   prdata;
	logic                         pready;

	tach_scoreboard sb = new();
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int quiet_cycles = 0;

	pulse_tachometer_overspeed uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.speed_rpm(speed_rpm),
		.over_speed(over_speed),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random with the current stall rate.
	initial out_stall = 1'b0;
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99, 0) < rx_stall_pct);
	end

	// Every accepted beat goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_pin(pin_level);
			if (out_valid && !out_stall)
				sb.check_speed(speed_rpm, over_speed);
		end
	end

	// Watchdog on cycles without any beat or register access.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("pulse_tachometer_overspeed_tb: done, errors");
			$finish;
		end
	end

	// One pin beat, with random idle cycles ahead of it; held while stalled.
	task automatic send_pin(input bit pin);
		while ($urandom_range(99, 0) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pin_level <= pin;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_run(input bit pin, input int len);
		repeat (len) send_pin(pin);
	endtask

	// Mostly clean pulse trains, with some noise bursts and long low phases; short_mode sends short clean pulses only.
	task automatic send_items(input int count, input bit short_mode);
		int sent;
		int roll;
		int high_len;
		int low_len;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(99, 0);
			if (!short_mode && roll < 10) begin
				high_len = $urandom_range(6, 1);
				repeat (high_len) send_pin(1'($urandom_range(1, 0)));
				sent += high_len;
			end else begin
				high_len = short_mode ? $urandom_range(2, 1) : $urandom_range(4, 1);
				if (short_mode)
					low_len = $urandom_range(2, 1);
				else if (roll < 20)
					low_len = $urandom_range(60, 7);
				else
					low_len = $urandom_range(6, 1);
				send_run(1'b1, high_len);
				send_run(1'b0, low_len);
				sent += high_len + low_len;
			end
		end
	endtask

	// Stop sending, wait out every expected beat and the divider.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_HOLD) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle.
	task automatic wr_reg(input logic [pto_pkg::IDX_W-1:0] idx,
			input bit [pto_pkg::DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= pto_pkg::ADDR_W'({idx, 3'b000});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Threshold close to the likely speed so that the flag goes both ways.
	function automatic bit [pto_pkg::SPEED_W-1:0] threshold_near(
			bit [pto_pkg::SCALE_W-1:0] scale, int ppm);
		bit [63:0] guess;
		guess = 64'(scale) / 64'((ppm == 0 ? 1 : ppm) * $urandom_range(8, 2));
		return (guess > 64'(pto_pkg::SPEED_MAX)) ? pto_pkg::SPEED_MAX :
			guess[pto_pkg::SPEED_W-1:0];
	endfunction

	// Idle block, new register values (upper data bits random), then a stretch of pulses.
	task automatic run_phase(input bit [pto_pkg::SCALE_W-1:0] scale,
			input bit [pto_pkg::SPEED_W-1:0] maxs, input bit [pto_pkg::PPM_W-1:0] ppm,
			input int items, input bit short_mode, input int profile);
		bit [pto_pkg::DATA_W-1:0] word;
		drain();
		word = {$urandom, $urandom};
		word[pto_pkg::SCALE_W-1:0] = scale;
		wr_reg(pto_pkg::REG_SCALE, word);
		word = {$urandom, $urandom};
		word[pto_pkg::SPEED_W-1:0] = maxs;
		wr_reg(pto_pkg::REG_MAX_SPEED, word);
		word = {$urandom, $urandom};
		word[pto_pkg::PPM_W-1:0] = ppm;
		wr_reg(pto_pkg::REG_PPM, word);
		unique case (profile)
			1: begin
				tx_idle_pct = 56;
				rx_stall_pct = 0;
			end
			2: begin
				tx_idle_pct = 0;
				rx_stall_pct = 56;
			end
			3: begin
				tx_idle_pct = 31;
				rx_stall_pct = 31;
			end
			default: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
		endcase
		send_items(items, short_mode);
	endtask

	initial begin
		bit [pto_pkg::SCALE_W-1:0] scale;
		int ppm;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pin_level = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: three sync pulses, then eleven one-tick low pulses.
		send_pin(1'b1);
		repeat (3) begin
			send_pin(1'b0);
			send_pin(1'b1);
		end
		repeat (11) begin
			send_pin(1'b0);
			send_pin(1'b1);
		end

		// Zero pulses per measure, full scale: speed saturates on short low phases, flag always set.
		run_phase({pto_pkg::SCALE_W{1'b1}}, '0, '0, 120, 1'b0, 0);
		// Smallest scale against the highest threshold.
		run_phase(33'd1, pto_pkg::SPEED_MAX, 7'd1, 120, 1'b0, 1);
		scale = 33'({$urandom, $urandom}) | 33'd1;
		ppm = $urandom_range(4, 2);
		run_phase(scale, threshold_near(scale, ppm), 7'(ppm), 160, 1'b0, 2);
		scale = 33'({$urandom, $urandom}) | 33'd1;
		run_phase(scale, threshold_near(scale, 64), 7'd64, 250, 1'b1, 3);
		// Widest pulse count; the next phase lowers it mid-measurement.
		scale = 33'({$urandom, $urandom}) | 33'd1;
		run_phase(scale, threshold_near(scale, 127), {pto_pkg::PPM_W{1'b1}}, 400, 1'b1, 0);
		for (int i = 1; i <= 3; i++) begin
			scale = 33'({$urandom, $urandom}) | 33'd1;
			ppm = $urandom_range(8, 1);
			run_phase(scale, threshold_near(scale, ppm), 7'(ppm), 60, 1'b0, i);
		end

		drain();
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("pulse_tachometer_overspeed_tb: done, clean");
		else
			$display("pulse_tachometer_overspeed_tb: done, errors");
		$finish;
	end

endmodule

>>> pulse_tachometer_overspeed.f
+incdir+hdl
hdl/pto_pkg.sv
hdl/pto_front.sv
hdl/pto_fifo.sv
hdl/pto_back.sv
hdl/pulse_tachometer_overspeed.sv
hdl/pto_checker.sv
tb/pulse_tachometer_overspeed_tb.sv
